[hw/rtl/ats_pkg.sv]
`timescale 1ns / 1ps
// Shared types, constants and helper functions for the assembly token scanner.
// No dependencies; every other file refers to this package by scoped names.
package ats_pkg;

  // Width of the internal position, length and line counters.
  localparam int POS_W = 16;

  // Token queue between the scanner and the output port.
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  // Token kinds.
  localparam logic [5:0] K_EOF        = 6'd0;
  localparam logic [5:0] K_NEWLINE    = 6'd1;
  localparam logic [5:0] K_COLON      = 6'd2;
  localparam logic [5:0] K_COMMA      = 6'd3;
  localparam logic [5:0] K_LBRACKET   = 6'd4;
  localparam logic [5:0] K_RBRACKET   = 6'd5;
  localparam logic [5:0] K_IDENT      = 6'd6;
  localparam logic [5:0] K_NUMBER     = 6'd7;
  localparam logic [5:0] K_STRING     = 6'd8;
  localparam logic [5:0] K_BAD_CHAR   = 6'd9;
  localparam logic [5:0] K_BAD_BASE   = 6'd10;
  localparam logic [5:0] K_MNEM_BASE  = 6'd11;

  // Mnemonic table: first five bytes of each word, first byte in the low byte.
  localparam int KW_COUNT = 25;
  localparam int KW_MAX   = 5;

  localparam logic [39:0] KW_PREFIX [KW_COUNT] = '{
    40'h0000646461, // add
    40'h0000646e61, // and
    40'h0000727361, // asr
    40'h0000000062, // b
    40'h0071652e62, // b.eq
    40'h0074672e62, // b.gt
    40'h0065672e62, // b.ge
    40'h00746c2e62, // b.lt
    40'h00656c2e62, // b.le
    40'h00656e2e62, // b.ne
    40'h006c6c6163, // call
    40'h0000706d63, // cmp
    40'h755f706d63, // cmp_u
    40'h0000726f65, // eor
    40'h0064616f6c, // load
    40'h00006c736c, // lsl
    40'h000072736c, // lsr
    40'h0000766f6d, // mov
    40'h0000706f6e, // nop
    40'h000072726f, // orr
    40'h746e697270, // print
    40'h0000747570, // put
    40'h0000746572, // ret
    40'h65726f7473, // store
    40'h0000627573  // sub
  };

  localparam logic [2:0] KW_LEN [KW_COUNT] = '{
    3'd3, 3'd3, 3'd3, 3'd1, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4,
    3'd4, 3'd3, 3'd5, 3'd3, 3'd4, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3,
    3'd5, 3'd3, 3'd3, 3'd5, 3'd3
  };

  typedef struct packed {
    logic [5:0]       kind;
    logic [POS_W-1:0] off;
    logic [POS_W-1:0] len;
    logic [POS_W-1:0] line;
    logic [POS_W-1:0] col;
    logic             last;
  } tok_t;

  function automatic logic [POS_W-1:0] sat_inc(input logic [POS_W-1:0] v);
    sat_inc = (v != {POS_W{1'b1}}) ? v + POS_W'(1) : v;
  endfunction

  function automatic tok_t make_tok(input logic [5:0] kind,
                                    input logic [POS_W-1:0] off,
                                    input logic [POS_W-1:0] len,
                                    input logic [POS_W-1:0] line,
                                    input logic [POS_W-1:0] col);
    tok_t t;
    t.kind = kind;
    t.off  = off;
    t.len  = len;
    t.line = line;
    t.col  = col;
    t.last = 1'b0;
    make_tok = t;
  endfunction

  // All table entries are compared in parallel; at most one can match.
  function automatic logic [5:0] word_kind(input logic [39:0] prefix,
                                           input logic [POS_W-1:0] len);
    logic [5:0] k;
    k = K_IDENT;
    if (len <= POS_W'(KW_MAX)) begin
      for (int i = 0; i < KW_COUNT; i++) begin
        if (len == POS_W'(KW_LEN[i]) && prefix == KW_PREFIX[i]) begin
          k = K_MNEM_BASE + 6'(i);
        end
      end
    end
    word_kind = k;
  endfunction

endpackage

[hw/rtl/ats_scanner.sv]
`timescale 1ns / 1ps
// Scanner state machine: position counters, current token and mnemonic match.
// Depends on ats_pkg for the token type, kinds and helper functions.
module ats_scanner (
  input  logic            clk,
  input  logic            rst,
  input  logic            fire,
  input  logic [7:0]      byte_in,
  output ats_pkg::tok_t   tok0,
  output ats_pkg::tok_t   tok1,
  output logic [1:0]      tok_cnt
);

  localparam logic [3:0] M_IDLE    = 4'd0;
  localparam logic [3:0] M_SLASH   = 4'd1;
  localparam logic [3:0] M_COMMENT = 4'd2;
  localparam logic [3:0] M_IDENT   = 4'd3;
  localparam logic [3:0] M_ZERO    = 4'd4;
  localparam logic [3:0] M_DEC     = 4'd5;
  localparam logic [3:0] M_BINPRE  = 4'd6;
  localparam logic [3:0] M_BIN     = 4'd7;
  localparam logic [3:0] M_HEXPRE  = 4'd8;
  localparam logic [3:0] M_HEX     = 4'd9;
  localparam logic [3:0] M_STRING  = 4'd10;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_LBRK  = 8'h5B;
  localparam logic [7:0] CH_RBRK  = 8'h5D;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_X     = 8'h78;

  localparam int PW = ats_pkg::POS_W;

  logic [3:0]    mode, mode_next;
  logic [39:0]   prefix, prefix_next;
  logic [PW-1:0] tso, tso_next;
  logic [PW-1:0] tlen, tlen_next;
  logic [PW-1:0] tsl, tsl_next;
  logic [PW-1:0] tsc, tsc_next;
  logic [PW-1:0] coff, coff_next;
  logic [PW-1:0] cline, cline_next;
  logic [PW-1:0] ccol, ccol_next;

  logic          is_word, is_dec, is_hex, is_bin;

  logic          idle_emit, idle_begin, idle_ident;
  logic [3:0]    idle_mode;
  logic [5:0]    idle_kind;
  logic [PW-1:0] idle_len, idle_off, idle_col;
  ats_pkg::tok_t idle_tok;

  logic          held_vld, do_idle;
  ats_pkg::tok_t held_tok;
  logic          two;

  always_comb begin
    is_word = (byte_in >= 8'h61 && byte_in <= 8'h7A) || (byte_in >= 8'h41 && byte_in <= 8'h5A)
              || byte_in == 8'h5F || byte_in == 8'h2E;
    is_dec  = byte_in >= CH_ZERO && byte_in <= 8'h39;
    is_hex  = is_dec || (byte_in >= 8'h61 && byte_in <= 8'h66)
              || (byte_in >= 8'h41 && byte_in <= 8'h46);
    is_bin  = byte_in == CH_ZERO || byte_in == CH_ONE;
  end

  // What a byte does when no token is open.
  always_comb begin
    idle_emit  = 1'b0;
    idle_begin = 1'b0;
    idle_ident = 1'b0;
    idle_mode  = M_IDLE;
    idle_kind  = ats_pkg::K_EOF;
    idle_len   = '0;
    idle_off   = coff;
    idle_col   = ccol;
    if (byte_in == CH_SPACE || byte_in == CH_TAB || byte_in == CH_CR || byte_in == CH_NUL) begin
      idle_emit = (byte_in == CH_NUL);
    end else if (byte_in == CH_SLASH) begin
      idle_begin = 1'b1;
      idle_mode  = M_SLASH;
    end else if (is_word) begin
      idle_begin = 1'b1;
      idle_ident = 1'b1;
      idle_mode  = M_IDENT;
      idle_len   = PW'(1);
    end else if (is_dec) begin
      idle_begin = 1'b1;
      idle_mode  = (byte_in == CH_ZERO) ? M_ZERO : M_DEC;
      idle_len   = PW'(1);
    end else if (byte_in == CH_QUOTE) begin
      // String content starts after the opening quote.
      idle_begin = 1'b1;
      idle_mode  = M_STRING;
      idle_off   = ats_pkg::sat_inc(coff);
      idle_col   = ats_pkg::sat_inc(ccol);
    end else begin
      idle_emit = 1'b1;
      idle_len  = PW'(1);
      if (byte_in == CH_LF || byte_in == CH_SEMI) begin
        idle_kind = ats_pkg::K_NEWLINE;
      end else if (byte_in == CH_COLON) begin
        idle_kind = ats_pkg::K_COLON;
      end else if (byte_in == CH_COMMA) begin
        idle_kind = ats_pkg::K_COMMA;
      end else if (byte_in == CH_LBRK) begin
        idle_kind = ats_pkg::K_LBRACKET;
      end else if (byte_in == CH_RBRK) begin
        idle_kind = ats_pkg::K_RBRACKET;
      end else begin
        idle_kind = ats_pkg::K_BAD_CHAR;
        idle_len  = '0;
      end
    end
    idle_tok = ats_pkg::make_tok(idle_kind, coff, idle_len, cline, ccol);
  end

  always_comb begin
    mode_next   = mode;
    prefix_next = prefix;
    tso_next    = tso;
    tlen_next   = tlen;
    tsl_next    = tsl;
    tsc_next    = tsc;
    held_vld    = 1'b0;
    held_tok    = ats_pkg::make_tok(ats_pkg::K_NUMBER, tso, tlen, tsl, tsc);
    do_idle     = 1'b0;

    case (mode)
      M_SLASH: begin
        if (byte_in == CH_SLASH) begin
          mode_next = M_COMMENT;
        end else begin
          held_vld = 1'b1;
          held_tok = ats_pkg::make_tok(ats_pkg::K_BAD_CHAR, tso, '0, tsl, tsc);
          do_idle  = 1'b1;
        end
      end
      M_COMMENT: begin
        do_idle = (byte_in == CH_LF || byte_in == CH_NUL);
      end
      M_IDENT: begin
        if (is_word || is_dec) begin
          for (int i = 0; i < ats_pkg::KW_MAX; i++) begin
            if (tlen == PW'(i)) begin
              prefix_next[8*i +: 8] = byte_in;
            end
          end
          tlen_next = ats_pkg::sat_inc(tlen);
        end else begin
          held_vld = 1'b1;
          held_tok = ats_pkg::make_tok(ats_pkg::word_kind(prefix, tlen), tso, tlen, tsl, tsc);
          do_idle  = 1'b1;
        end
      end
      M_ZERO: begin
        if (byte_in == CH_B) begin
          mode_next = M_BINPRE;
          tlen_next = ats_pkg::sat_inc(tlen);
        end else if (byte_in == CH_X) begin
          mode_next = M_HEXPRE;
          tlen_next = ats_pkg::sat_inc(tlen);
        end else if (is_dec) begin
          mode_next = M_DEC;
          tlen_next = ats_pkg::sat_inc(tlen);
        end else begin
          held_vld = 1'b1;
          do_idle  = 1'b1;
        end
      end
      M_DEC: begin
        if (is_dec) begin
          tlen_next = ats_pkg::sat_inc(tlen);
        end else begin
          held_vld = 1'b1;
          do_idle  = 1'b1;
        end
      end
      M_BINPRE, M_HEXPRE: begin
        if ((mode == M_BINPRE) ? is_bin : is_hex) begin
          mode_next = (mode == M_BINPRE) ? M_BIN : M_HEX;
          tlen_next = ats_pkg::sat_inc(tlen);
        end else begin
          // The error points at the base letter.
          held_vld = 1'b1;
          held_tok = ats_pkg::make_tok(ats_pkg::K_BAD_BASE, ats_pkg::sat_inc(tso), '0, tsl,
                                       ats_pkg::sat_inc(tsc));
          do_idle  = 1'b1;
        end
      end
      M_BIN: begin
        if (is_bin) begin
          tlen_next = ats_pkg::sat_inc(tlen);
        end else begin
          held_vld = 1'b1;
          do_idle  = 1'b1;
        end
      end
      M_HEX: begin
        if (is_hex) begin
          tlen_next = ats_pkg::sat_inc(tlen);
        end else begin
          held_vld = 1'b1;
          do_idle  = 1'b1;
        end
      end
      M_STRING: begin
        held_tok = ats_pkg::make_tok(ats_pkg::K_STRING, tso, tlen, tsl, tsc);
        if (byte_in == CH_QUOTE) begin
          held_vld  = 1'b1;
          mode_next = M_IDLE;
        end else if (byte_in == CH_NUL) begin
          held_vld = 1'b1;
          do_idle  = 1'b1;
        end else begin
          tlen_next = ats_pkg::sat_inc(tlen);
        end
      end
      default: begin
        do_idle = 1'b1;
      end
    endcase

    if (do_idle) begin
      mode_next = idle_mode;
      if (idle_begin) begin
        tso_next  = idle_off;
        tsl_next  = cline;
        tsc_next  = idle_col;
        tlen_next = idle_len;
      end
      if (idle_ident) begin
        prefix_next = {32'd0, byte_in};
      end
    end

    coff_next  = ats_pkg::sat_inc(coff);
    cline_next = cline;
    ccol_next  = ats_pkg::sat_inc(ccol);
    if (byte_in == CH_LF) begin
      cline_next = ats_pkg::sat_inc(cline);
      ccol_next  = PW'(1);
    end

    // End of text returns the whole scanner to its reset state.
    if (byte_in == CH_NUL) begin
      mode_next   = M_IDLE;
      prefix_next = '0;
      tso_next    = '0;
      tlen_next   = '0;
      tsl_next    = PW'(1);
      tsc_next    = PW'(1);
      coff_next   = '0;
      cline_next  = PW'(1);
      ccol_next   = PW'(1);
    end
  end

  always_comb begin
    two = held_vld && do_idle && idle_emit;
    if (held_vld) begin
      tok0 = held_tok;
    end else begin
      tok0 = idle_tok;
    end
    tok1      = idle_tok;
    tok0.last = !two;
    tok1.last = 1'b1;
    if (two) begin
      tok_cnt = 2'd2;
    end else if (held_vld || (do_idle && idle_emit)) begin
      tok_cnt = 2'd1;
    end else begin
      tok_cnt = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= M_IDLE;
      prefix <= '0;
      tso    <= '0;
      tlen   <= '0;
      tsl    <= PW'(1);
      tsc    <= PW'(1);
      coff   <= '0;
      cline  <= PW'(1);
      ccol   <= PW'(1);
    end else if (fire) begin
      mode   <= mode_next;
      prefix <= prefix_next;
      tso    <= tso_next;
      tlen   <= tlen_next;
      tsl    <= tsl_next;
      tsc    <= tsc_next;
      coff   <= coff_next;
      cline  <= cline_next;
      ccol   <= ccol_next;
    end
  end

endmodule

[hw/rtl/ats_fifo.sv]
`timescale 1ns / 1ps
// Small token queue: takes up to two tokens per cycle, gives one per cycle.
// Depends on ats_pkg for the token type and the queue depth.
module ats_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic [1:0]      push_cnt,
  input  ats_pkg::tok_t   din0,
  input  ats_pkg::tok_t   din1,
  input  logic            pop,
  output ats_pkg::tok_t   head,
  output logic            not_empty,
  output logic            room2
);

  localparam int AW = ats_pkg::FIFO_AW;

  ats_pkg::tok_t mem [ats_pkg::FIFO_DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [AW:0]   count, count_next;

  assign head      = mem[rd_ptr];
  assign not_empty = (count != '0);
  assign room2     = (count <= (AW+1)'(ats_pkg::FIFO_DEPTH - 2));

  always_comb begin
    count_next = count + (AW+1)'(push_cnt) - (AW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      mem[wr_ptr] <= din0;
    end
    if (push_cnt == 2'd2) begin
      mem[wr_ptr + AW'(1)] <= din1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + AW'(push_cnt);
      rd_ptr <= rd_ptr + AW'(pop);
      count  <= count_next;
    end
  end

endmodule

[hw/rtl/assembly_token_scanner_core.sv]
`timescale 1ns / 1ps
// Top level of the assembly token scanner: input register, scanner, token queue.
// Depends on ats_pkg, ats_scanner and ats_fifo.
//
//   Port group   Dir   Beat contents
//   in_*         in    text_byte: one source byte, 0 ends the text
//   out_*        out   token_kind, start_offset, content_length, line_number,
//                      column_number, last_of_item: one token
//
// One byte is taken per cycle while in_stall is low; each byte gives zero, one
// or two tokens, and the output sends one token per cycle while out_stall is low,
// so two-token bytes set the long-run rate; tokens leave through the token queue.
// The scanner runs a byte only when the four-entry token queue has two free
// places; otherwise the byte waits in the input register and in_stall rises.
// rst clears the scanner state, positions and queue.
module assembly_token_scanner_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  text_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [5:0]  token_kind,
  output logic [15:0] start_offset,
  output logic [15:0] content_length,
  output logic [15:0] line_number,
  output logic [15:0] column_number,
  output logic        last_of_item
);

  logic          in_full;
  logic [7:0]    in_byte;
  logic          fire;
  logic          room2;
  logic [1:0]    tok_cnt, push_cnt;
  ats_pkg::tok_t tok0, tok1, head;

  assign fire     = in_full && room2;
  assign in_stall = in_full && !room2;
  assign push_cnt = fire ? tok_cnt : 2'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_full <= 1'b1;
    end else if (fire) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_byte <= text_byte;
    end
  end

  ats_scanner u_scanner (
    .clk     (clk),
    .rst     (rst),
    .fire    (fire),
    .byte_in (in_byte),
    .tok0    (tok0),
    .tok1    (tok1),
    .tok_cnt (tok_cnt)
  );

  ats_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push_cnt  (push_cnt),
    .din0      (tok0),
    .din1      (tok1),
    .pop       (out_valid && !out_stall),
    .head      (head),
    .not_empty (out_valid),
    .room2     (room2)
  );

  assign token_kind     = head.kind;
  assign start_offset   = 16'(head.off);
  assign content_length = 16'(head.len);
  assign line_number    = 16'(head.line);
  assign column_number  = 16'(head.col);
  assign last_of_item   = head.last;

endmodule

[bench/tb.sv]
`timescale 1ns / 1ps
// Self-checking bench for assembly_token_scanner_core: directed and random texts.
// Depends on ats_pkg and the scanner RTL; a built-in token predictor checks each output beat.
module tb;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int TAIL_CYCLES    = 20;
  localparam int RANDOM_BYTES   = 800;
  localparam int REPORT_MAX     = 10;

  localparam string DIGITS    = "0123456789";
  localparam string HEX_CHARS = "0123456789abcdefABCDEF";
  localparam string WORD_HEAD = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_.";
  localparam string WORD_TAIL =
    "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_.0123456789";
  localparam string PUNCT     = "\n;:,[]";
  localparam string BLANKS    = " \t\r";

  typedef enum logic [3:0] {
    S_IDLE, S_SLASH, S_COMMENT, S_WORD, S_ZERO, S_DEC,
    S_BINPRE, S_BIN, S_HEXPRE, S_HEX, S_STRING
  } scan_state_e;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  text_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [5:0]  token_kind;
  logic [15:0] start_offset;
  logic [15:0] content_length;
  logic [15:0] line_number;
  logic [15:0] column_number;
  logic        last_of_item;

  assembly_token_scanner_core i_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .text_byte      (text_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .token_kind     (token_kind),
    .start_offset   (start_offset),
    .content_length (content_length),
    .line_number    (line_number),
    .column_number  (column_number),
    .last_of_item   (last_of_item)
  );

  always #5 clk = ~clk;

  string mnemonics [ats_pkg::KW_COUNT] = '{
    "add", "and", "asr", "b", "b.eq", "b.gt", "b.ge", "b.lt", "b.le", "b.ne",
    "call", "cmp", "cmp_u", "eor", "load", "lsl", "lsr", "mov", "nop", "orr",
    "print", "put", "ret", "store", "sub"
  };

  // Predictor state.
  scan_state_e   scan_state;
  logic [39:0]   word_bytes;
  logic [15:0]   tok_off, tok_len, tok_line, tok_col;
  logic [15:0]   cur_off, cur_line, cur_col;
  ats_pkg::tok_t step_tok [2];
  int            step_count;
  ats_pkg::tok_t expected_tokens [$];

  logic [7:0]    text_buf [$];
  int            gap_pct = 0;
  int            stall_pct = 0;
  int            stall_left = 0;
  int            mismatches = 0;
  int            idle_cycles = 0;
  ats_pkg::tok_t seen_tok, want_tok;

  function automatic logic [15:0] sat16(input logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  function automatic bit is_head(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_" || c == ".";
  endfunction

  function automatic bit is_dec(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_hex(input logic [7:0] c);
    return is_dec(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
  endfunction

  function automatic logic [5:0] classify_word(input logic [39:0] w, input logic [15:0] n);
    logic [39:0] p;
    logic [5:0]  k;
    k = ats_pkg::K_IDENT;
    if (n <= 16'd5) begin
      for (int i = 0; i < ats_pkg::KW_COUNT; i++) begin
        p = '0;
        for (int j = 0; j < mnemonics[i].len(); j++) p[8*j +: 8] = mnemonics[i][j];
        if (mnemonics[i].len() == n && p == w) k = ats_pkg::K_MNEM_BASE + 6'(i);
      end
    end
    return k;
  endfunction

  function automatic void reset_scanner();
    scan_state = S_IDLE;
    word_bytes = '0;
    tok_off    = 16'd0;
    tok_len    = 16'd0;
    tok_line   = 16'd1;
    tok_col    = 16'd1;
    cur_off    = 16'd0;
    cur_line   = 16'd1;
    cur_col    = 16'd1;
  endfunction

  function automatic void add_token(input logic [5:0] k, input logic [15:0] o,
                                    input logic [15:0] n, input logic [15:0] ln,
                                    input logic [15:0] c);
    if (step_count < 2) begin
      step_tok[step_count] = {k, o, n, ln, c, 1'b0};
      step_count++;
    end
  endfunction

  function automatic void add_held(input logic [5:0] k);
    add_token(k, tok_off, tok_len, tok_line, tok_col);
  endfunction

  function automatic void open_token(input scan_state_e m, input logic [15:0] n);
    scan_state = m;
    tok_off    = cur_off;
    tok_line   = cur_line;
    tok_col    = cur_col;
    tok_len    = n;
  endfunction

  function automatic void extend(input scan_state_e m);
    scan_state = m;
    tok_len    = sat16(tok_len);
  endfunction

  // A byte seen with no token open.
  function automatic void scan_fresh(input logic [7:0] b);
    logic [5:0] k;
    scan_state = S_IDLE;
    if (b == " " || b == "\t" || b == "\r" || b == 8'h00) begin
      if (b == 8'h00) add_token(ats_pkg::K_EOF, cur_off, 16'd0, cur_line, cur_col);
    end else if (b == "/") begin
      open_token(S_SLASH, 16'd0);
    end else if (is_head(b)) begin
      open_token(S_WORD, 16'd1);
      word_bytes = {32'd0, b};
    end else if (is_dec(b)) begin
      open_token((b == "0") ? S_ZERO : S_DEC, 16'd1);
    end else if (b == "\"") begin
      // String positions point past the opening quote.
      open_token(S_STRING, 16'd0);
      tok_off = sat16(cur_off);
      tok_col = sat16(cur_col);
    end else begin
      case (b)
        "\n", ";": k = ats_pkg::K_NEWLINE;
        ":":       k = ats_pkg::K_COLON;
        ",":       k = ats_pkg::K_COMMA;
        "[":       k = ats_pkg::K_LBRACKET;
        "]":       k = ats_pkg::K_RBRACKET;
        default:   k = ats_pkg::K_BAD_CHAR;
      endcase
      add_token(k, cur_off, (k == ats_pkg::K_BAD_CHAR) ? 16'd0 : 16'd1,
                cur_line, cur_col);
    end
  endfunction

  function automatic void predict_tokens(input logic [7:0] b);
    step_count = 0;
    case (scan_state)
      S_SLASH: begin
        if (b == "/") begin
          scan_state = S_COMMENT;
        end else begin
          add_token(ats_pkg::K_BAD_CHAR, tok_off, 16'd0, tok_line, tok_col);
          scan_fresh(b);
        end
      end
      S_COMMENT: begin
        if (b == "\n" || b == 8'h00) scan_fresh(b);
      end
      S_WORD: begin
        if (is_head(b) || is_dec(b)) begin
          if (tok_len < 16'd5) word_bytes = word_bytes | (40'(b) << (8 * tok_len));
          extend(S_WORD);
        end else begin
          add_held(classify_word(word_bytes, tok_len));
          scan_fresh(b);
        end
      end
      S_ZERO: begin
        if (b == "b") extend(S_BINPRE);
        else if (b == "x") extend(S_HEXPRE);
        else if (is_dec(b)) extend(S_DEC);
        else begin
          add_held(ats_pkg::K_NUMBER);
          scan_fresh(b);
        end
      end
      S_DEC: begin
        if (is_dec(b)) extend(S_DEC);
        else begin
          add_held(ats_pkg::K_NUMBER);
          scan_fresh(b);
        end
      end
      S_BINPRE, S_HEXPRE: begin
        if ((scan_state == S_BINPRE) ? (b == "0" || b == "1") : is_hex(b)) begin
          extend((scan_state == S_BINPRE) ? S_BIN : S_HEX);
        end else begin
          // The error sits on the base letter, one place after the leading zero.
          add_token(ats_pkg::K_BAD_BASE, sat16(tok_off), 16'd0, tok_line, sat16(tok_col));
          scan_fresh(b);
        end
      end
      S_BIN: begin
        if (b == "0" || b == "1") extend(S_BIN);
        else begin
          add_held(ats_pkg::K_NUMBER);
          scan_fresh(b);
        end
      end
      S_HEX: begin
        if (is_hex(b)) extend(S_HEX);
        else begin
          add_held(ats_pkg::K_NUMBER);
          scan_fresh(b);
        end
      end
      S_STRING: begin
        if (b == "\"") begin
          add_held(ats_pkg::K_STRING);
          scan_state = S_IDLE;
        end else if (b == 8'h00) begin
          add_held(ats_pkg::K_STRING);
          scan_fresh(b);
        end else begin
          extend(S_STRING);
        end
      end
      default: scan_fresh(b);
    endcase

    if (b == 8'h00) begin
      reset_scanner();
    end else begin
      cur_off = sat16(cur_off);
      if (b == "\n") begin
        cur_line = sat16(cur_line);
        cur_col  = 16'd1;
      end else begin
        cur_col = sat16(cur_col);
      end
    end

    if (step_count != 0) step_tok[step_count - 1].last = 1'b1;
    for (int i = 0; i < step_count; i++) expected_tokens.push_back(step_tok[i]);
  endfunction

  // Mostly no delay, otherwise a short one, now and then a long one.
  function automatic int pick_delay(input int pct);
    if ($urandom_range(99) >= pct) return 0;
    if ($urandom_range(9) == 0) return $urandom_range(40, 12);
    return $urandom_range(3, 1);
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = pick_delay(gap_pct);
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid  <= 1'b1;
    text_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_tokens(b);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  function automatic void push_str(input string s);
    for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
  endfunction

  function automatic logic [7:0] pick_char(input string set);
    return set[$urandom_range(set.len() - 1)];
  endfunction

  // Any nonzero byte other than the one given.
  function automatic logic [7:0] random_byte_except(input logic [7:0] avoid);
    logic [7:0] c;
    c = 8'($urandom_range(255, 1));
    if (c == avoid) c = "a";
    return c;
  endfunction

  function automatic void add_lexeme();
    string s;
    int    n;
    case ($urandom_range(15))
      0, 1: push_str(mnemonics[$urandom_range(ats_pkg::KW_COUNT - 1)]);
      2: begin
        // Words that come close to a mnemonic.
        s = mnemonics[$urandom_range(ats_pkg::KW_COUNT - 1)];
        if ($urandom_range(1) == 0 || s.len() < 2) begin
          push_str(s);
          text_buf.push_back(pick_char(WORD_TAIL));
        end else begin
          push_str(s.substr(0, s.len() - 2));
        end
      end
      3: begin
        n = ($urandom_range(7) == 0) ? $urandom_range(12, 6) : $urandom_range(4);
        text_buf.push_back(pick_char(WORD_HEAD));
        repeat (n) text_buf.push_back(pick_char(WORD_TAIL));
      end
      4: begin
        n = $urandom_range(4);
        text_buf.push_back(($urandom_range(3) == 0) ? 8'("0") : 8'($urandom_range(57, 49)));
        repeat (n) text_buf.push_back(pick_char(DIGITS));
      end
      5: begin
        push_str("0b");
        repeat ($urandom_range(8, 1)) text_buf.push_back(pick_char("01"));
      end
      6: begin
        push_str("0x");
        repeat ($urandom_range(6, 1)) text_buf.push_back(pick_char(HEX_CHARS));
      end
      7: begin
        push_str(($urandom_range(1) == 0) ? "0b" : "0x");
        text_buf.push_back(pick_char(" ,;g]\n2"));
      end
      8: begin
        text_buf.push_back("\"");
        repeat ($urandom_range(10)) begin
          text_buf.push_back(($urandom_range(5) == 0) ? 8'("\n") : random_byte_except("\""));
        end
        text_buf.push_back("\"");
      end
      9: begin
        push_str("//");
        repeat ($urandom_range(6)) text_buf.push_back(random_byte_except("\n"));
        text_buf.push_back("\n");
      end
      10, 11: text_buf.push_back(pick_char(PUNCT));
      12: text_buf.push_back(pick_char(BLANKS));
      13: text_buf.push_back("/");
      default: text_buf.push_back(8'($urandom_range(255, 1)));
    endcase
    if ($urandom_range(9) < 6) text_buf.push_back(($urandom_range(3) == 0) ?
                                                  pick_char(BLANKS) : 8'(" "));
  endfunction

  task automatic test_directed_cases();
    gap_pct   = 20;
    stall_pct = 20;
    send_byte(8'h00);            // empty text
    send_text("0x;0b2/a");       // missing base digits, lone slash
    send_byte(8'hFF);            // byte outside the character set
    send_text("// c\n\"a\nb");   // comment, then a string over two lines
    send_byte(8'h00);            // ends the string without its closing quote
  endtask

  task automatic test_random_texts();
    int sent;
    sent = 0;
    while (sent < RANDOM_BYTES) begin
      text_buf.delete();
      case ($urandom_range(2))
        0: gap_pct = 0;
        1: gap_pct = 15;
        default: gap_pct = 50;
      endcase
      case ($urandom_range(2))
        0: stall_pct = 0;
        1: stall_pct = 15;
        default: stall_pct = 50;
      endcase
      repeat ($urandom_range(15)) add_lexeme();
      if ($urandom_range(7) == 0) begin
        text_buf.push_back("\"");
        repeat ($urandom_range(4)) text_buf.push_back(pick_char(WORD_TAIL));
      end
      text_buf.push_back(8'h00);
      foreach (text_buf[i]) send_byte(text_buf[i]);
      sent += text_buf.size();
    end
  endtask

  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      out_stall  <= 1'b0;
      stall_left <= pick_delay(stall_pct);
    end
  end

  task automatic report_token(input string what, input ats_pkg::tok_t want,
                              input ats_pkg::tok_t got);
    mismatches++;
    if (mismatches <= REPORT_MAX) begin
      $display("%s at %0t: expected kind %0d off %0d len %0d line %0d col %0d last %0b",
               what, $time, want.kind, want.off, want.len, want.line, want.col, want.last);
      $display("  got kind %0d off %0d len %0d line %0d col %0d last %0b",
               got.kind, got.off, got.len, got.line, got.col, got.last);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      seen_tok = {token_kind, start_offset, content_length, line_number, column_number,
                  last_of_item};
      if (expected_tokens.size() == 0) begin
        report_token("token beat with none predicted", '0, seen_tok);
      end else begin
        want_tok = expected_tokens.pop_front();
        if (seen_tok !== want_tok) report_token("token mismatch", want_tok, seen_tok);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    reset_scanner();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed_cases();
    test_random_texts();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_tokens.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/ats_pkg.sv
hw/rtl/ats_scanner.sv
hw/rtl/ats_fifo.sv
hw/rtl/assembly_token_scanner_core.sv
bench/tb.sv
